/* hdl/wfd_pkg.sv */
// Shared types, codes and constants of the wireless M-Bus deframer.
`timescale 1ns / 1ps
package wfd_pkg;

  localparam int A_FIRST_BLOCK = 10;
  localparam int A_OTHER_BLOCK = 16;
  localparam int B_FIRST_BLOCK = 126;
  localparam int B_SECOND_MAX  = 124;
  localparam int B_L_ADJUST    = 128;
  localparam int LINK_HDR_LEN  = 10;
  localparam int QDEPTH        = 2;

  localparam logic [7:0]  CI_ELL_SHORT = 8'h8C;
  localparam logic [7:0]  CI_AFL       = 8'h90;
  localparam logic [7:0]  CI_TPL_LONG  = 8'h72;
  localparam logic [14:0] SWAP_MAN     = 15'h2697;
  localparam logic [7:0]  SWAP_TYPE    = 8'h30;

  localparam logic [1:0] REG_WILD_MAN    = 2'd0;
  localparam logic [1:0] REG_WILD_TYPE   = 2'd1;
  localparam logic [1:0] REG_WILD_SERIAL = 2'd2;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_START,
    OP_EOP
  } op_t;

  typedef enum logic [2:0] {
    KIND_LINK,
    KIND_FIELD,
    KIND_AFL_LEN,
    KIND_TPL,
    KIND_DONE
  } kind_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  frame_byte;
    logic        start_of_frame;
    logic        format_b;
    logic [15:0] link_quality;
  } wfd_in_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] dev1_manufacturer;
    logic [7:0]  dev1_type;
    logic [31:0] dev1_serial;
    logic [7:0]  dev1_length;
    logic        dev2_present;
    logic [15:0] dev2_manufacturer;
    logic [7:0]  dev2_type;
    logic [31:0] dev2_serial;
    logic [7:0]  dev2_length;
    logic [31:0] checksum;
    logic [15:0] link_quality_out;
  } wfd_out_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic        format_b;
    logic [15:0] link_quality;
  } wfd_cmd_t;

  typedef struct packed {
    logic [15:0] man;
    logic [7:0]  dev_type;
    logic [31:0] serial;
    logic [7:0]  len;
  } wfd_id_t;

  typedef struct packed {
    logic [15:0] man;
    logic [7:0]  dev_type;
    logic [31:0] serial;
  } wfd_wild_t;

  function automatic logic id_valid(input wfd_id_t d, input wfd_wild_t w);
    return (d.man != w.man) && (d.dev_type != w.dev_type) &&
           (d.serial != w.serial) && (d.len != 8'd0);
  endfunction

endpackage

/* hdl/wfd_front.sv */
// Front end: classifies incoming requests and holds them in a short queue.
`timescale 1ns / 1ps
module wfd_front
  import wfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  wfd_in_t  in_data,
  output logic     q_valid,
  output wfd_cmd_t q_cmd,
  input  logic     q_pop
);

  localparam int PW = $clog2(QDEPTH);

  wfd_cmd_t         mem_r [QDEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  wfd_cmd_t         cmd;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    cmd.data         = in_data.frame_byte;
    cmd.format_b     = in_data.format_b;
    cmd.link_quality = in_data.link_quality;
    if (in_data.req_type) begin
      cmd.op = OP_EOP;
    end else if (in_data.start_of_frame) begin
      cmd.op = OP_START;
    end else begin
      cmd.op = OP_BYTE;
    end
  end

  assign in_full = (count_r == (PW+1)'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

/* hdl/wfd_outq.sv */
// Result queue that decouples the parser from the consumer.
`timescale 1ns / 1ps
module wfd_outq
  import wfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  wfd_out_t push_data,
  output logic     full,
  output logic     out_empty,
  input  logic     out_pop,
  output wfd_out_t out_data
);

  localparam int PW = $clog2(QDEPTH);

  wfd_out_t      mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full      = (count_r == (PW+1)'(QDEPTH));
  assign out_empty = (count_r == '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = out_pop && !out_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/wfd_back.sv */
// Back end: block/CRC deframing, header walk and result assembly.
`timescale 1ns / 1ps
module wfd_back
  import wfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        q_valid,
  input  wfd_cmd_t    q_cmd,
  output logic        q_pop,
  input  logic        res_full,
  output logic        res_push,
  output wfd_out_t    res_data
);

  wfd_wild_t   wild_r;
  logic        in_frame_r, in_frame_nxt;
  logic        is_b_r, is_b_nxt;
  logic        has2_r, has2_nxt;
  logic        done_r, done_nxt;
  logic        blk_no_r, blk_no_nxt;
  logic [8:0]  ds_r, ds_nxt;
  logic [8:0]  di_r, di_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [1:0]  crc_left_r, crc_left_nxt;
  logic [15:0] crc_word_r, crc_word_nxt;
  logic [31:0] fold_r, fold_nxt;
  logic [8:0]  nfp_r, nfp_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  hdr_len_r, hdr_len_nxt;
  wfd_id_t     id1_r, id1_nxt;
  wfd_id_t     id2_r, id2_nxt;

  wfd_id_t     wild_id;
  wfd_id_t     d1, d2;
  logic        swap;
  logic signed [9:0] e;
  logic [9:0]  b2;
  logic [8:0]  pos, left, k;
  logic [7:0]  b;

  assign wild_id = '{man: wild_r.man, dev_type: wild_r.dev_type,
                     serial: wild_r.serial, len: 8'd0};
  assign q_pop    = q_valid && ((q_cmd.op != OP_EOP) || !res_full);
  assign res_push = q_pop && (q_cmd.op == OP_EOP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wild_r <= '{man: 16'hFFFF, dev_type: 8'hFF, serial: 32'hFFFF_FFFF};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WILD_MAN:    wild_r.man      <= cfg_wdata[15:0];
        REG_WILD_TYPE:   wild_r.dev_type <= cfg_wdata[7:0];
        REG_WILD_SERIAL: wild_r.serial   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result assembly for an end-of-packet request.
  always_comb begin
    d1 = wild_id;
    d2 = wild_id;
    if (in_frame_r && done_r && (ds_r >= 9'(LINK_HDR_LEN))) begin
      d1 = id1_r;
      d2 = id2_r;
      if (kind_r == KIND_AFL_LEN) begin
        d1.len = 8'(ds_r - (nfp_r + 9'd2));
      end
    end
    swap = id_valid(d1, wild_r) && id_valid(d2, wild_r) &&
           (d1.man[14:0] == SWAP_MAN) && (d1.dev_type == SWAP_TYPE);
    res_data.ok                = id_valid(swap ? d2 : d1, wild_r);
    res_data.dev1_manufacturer = swap ? d2.man : d1.man;
    res_data.dev1_type         = swap ? d2.dev_type : d1.dev_type;
    res_data.dev1_serial       = swap ? d2.serial : d1.serial;
    res_data.dev1_length       = swap ? d2.len : d1.len;
    res_data.dev2_present      = id_valid(swap ? d1 : d2, wild_r);
    res_data.dev2_manufacturer = swap ? d1.man : d2.man;
    res_data.dev2_type         = swap ? d1.dev_type : d2.dev_type;
    res_data.dev2_serial       = swap ? d1.serial : d2.serial;
    res_data.dev2_length       = swap ? d1.len : d2.len;
    res_data.checksum          = in_frame_r ? fold_r : 32'd0;
    res_data.link_quality_out  = q_cmd.link_quality;
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    is_b_nxt     = is_b_r;
    has2_nxt     = has2_r;
    done_nxt     = done_r;
    blk_no_nxt   = blk_no_r;
    ds_nxt       = ds_r;
    di_nxt       = di_r;
    rem_nxt      = rem_r;
    crc_left_nxt = crc_left_r;
    crc_word_nxt = crc_word_r;
    fold_nxt     = fold_r;
    nfp_nxt      = nfp_r;
    kind_nxt     = kind_r;
    hdr_len_nxt  = hdr_len_r;
    id1_nxt      = id1_r;
    id2_nxt      = id2_r;
    e            = '0;
    b2           = '0;
    left         = '0;
    k            = '0;
    b            = q_cmd.data;
    pos          = di_r;
    if (q_pop) begin
      if (q_cmd.op == OP_EOP) begin
        in_frame_nxt = 1'b0;
      end else begin
        if (q_cmd.op == OP_START) begin
          in_frame_nxt = 1'b1;
          is_b_nxt     = q_cmd.format_b;
          done_nxt     = 1'b0;
          fold_nxt     = '0;
          crc_word_nxt = '0;
          di_nxt       = '0;
          blk_no_nxt   = 1'b0;
          nfp_nxt      = 9'(LINK_HDR_LEN);
          kind_nxt     = KIND_LINK;
          id1_nxt      = wild_id;
          id2_nxt      = wild_id;
          if (!q_cmd.format_b) begin
            ds_nxt      = {1'b0, b} + 9'd1;
            rem_nxt     = (ds_nxt < 9'(A_FIRST_BLOCK)) ? ds_nxt[7:0] : 8'(A_FIRST_BLOCK);
            has2_nxt    = 1'b0;
            hdr_len_nxt = '0;
          end else begin
            // Signed compares: an L byte of zero gives a negative size.
            e = $signed({2'b00, b}) - 10'sd1;
            if (e > $signed(10'(B_L_ADJUST))) begin
              e = e - 10'sd2;
            end
            has2_nxt = (e > $signed(10'(B_FIRST_BLOCK)));
            if (has2_nxt) begin
              b2 = e - 10'(B_FIRST_BLOCK + 1);
              if (b2 > 10'(B_SECOND_MAX)) begin
                b2 = 10'(B_SECOND_MAX);
              end
              ds_nxt  = 9'(B_FIRST_BLOCK) + b2[8:0];
              rem_nxt = 8'(B_FIRST_BLOCK);
            end else begin
              ds_nxt  = (e > 10'sd0) ? e[8:0] : 9'd0;
              rem_nxt = ds_nxt[7:0];
            end
            hdr_len_nxt = 8'(e - 10'sd1);
          end
          crc_left_nxt = (rem_nxt == 8'd0) ? 2'd2 : 2'd0;
        end
        pos = di_nxt;
        if (in_frame_nxt && !done_nxt) begin
          if (rem_nxt != 8'd0) begin
            // Data byte: walk the link header and the CI fields behind it.
            if (pos < 9'(LINK_HDR_LEN)) begin
              case (pos[3:0])
                4'd0: id1_nxt.len = is_b_nxt ? hdr_len_nxt : b;
                4'd2: id1_nxt.man[7:0] = b;
                4'd3: id1_nxt.man[15:8] = b;
                4'd4: id1_nxt.serial = {24'd0, b};
                4'd5: id1_nxt.serial[15:8] = id1_nxt.serial[15:8] | b;
                4'd6: id1_nxt.serial[23:16] = id1_nxt.serial[23:16] | b;
                4'd7: id1_nxt.serial[31:24] = id1_nxt.serial[31:24] | b;
                4'd9: begin
                  id1_nxt.dev_type = b;
                  kind_nxt         = KIND_FIELD;
                end
                default: ;
              endcase
            end else if (kind_nxt == KIND_FIELD && pos == nfp_nxt) begin
              if (b == CI_ELL_SHORT) begin
                nfp_nxt     = pos + 9'd3;
                id1_nxt.len = 8'(ds_nxt - nfp_nxt);
              end else if (b == CI_AFL) begin
                kind_nxt = KIND_AFL_LEN;
              end else if (b == CI_TPL_LONG) begin
                id2_nxt          = id1_nxt;
                id1_nxt.man      = '0;
                id1_nxt.dev_type = '0;
                id1_nxt.serial   = '0;
                kind_nxt         = KIND_TPL;
              end else begin
                kind_nxt = KIND_DONE;
              end
            end else if (kind_nxt == KIND_AFL_LEN &&
                         {1'b0, pos} == {1'b0, nfp_nxt} + 10'd1) begin
              nfp_nxt     = pos + 9'd1 + {1'b0, b};
              id1_nxt.len = 8'(ds_nxt - nfp_nxt);
              kind_nxt    = KIND_FIELD;
            end else if (kind_nxt == KIND_TPL && pos > nfp_nxt) begin
              k = pos - nfp_nxt;
              case (k)
                9'd1: id1_nxt.serial[7:0]   = id1_nxt.serial[7:0] | b;
                9'd2: id1_nxt.serial[15:8]  = id1_nxt.serial[15:8] | b;
                9'd3: id1_nxt.serial[23:16] = id1_nxt.serial[23:16] | b;
                9'd4: id1_nxt.serial[31:24] = id1_nxt.serial[31:24] | b;
                9'd5: id1_nxt.man[7:0]      = id1_nxt.man[7:0] | b;
                9'd6: id1_nxt.man[15:8]     = id1_nxt.man[15:8] | b;
                9'd8: begin
                  id1_nxt.dev_type = b;
                  kind_nxt         = KIND_DONE;
                end
                default: ;
              endcase
            end
            di_nxt  = di_nxt + 9'd1;
            rem_nxt = rem_nxt - 8'd1;
            if (rem_nxt == 8'd0) begin
              crc_left_nxt = 2'd2;
            end
          end else if (crc_left_nxt == 2'd0) begin
            done_nxt = 1'b1;
          end else begin
            crc_word_nxt = {crc_word_nxt[7:0], b};
            crc_left_nxt = crc_left_nxt - 2'd1;
            if (crc_left_nxt == 2'd0) begin
              fold_nxt = {fold_nxt[23:0], 8'd0} ^ {16'd0, crc_word_nxt};
              if (!is_b_nxt) begin
                if (di_nxt < ds_nxt) begin
                  left    = ds_nxt - di_nxt;
                  rem_nxt = (left < 9'(A_OTHER_BLOCK)) ? left[7:0] : 8'(A_OTHER_BLOCK);
                end else begin
                  done_nxt = 1'b1;
                end
              end else if (!blk_no_nxt && has2_nxt) begin
                blk_no_nxt = 1'b1;
                rem_nxt    = 8'(ds_nxt - di_nxt);
                if (rem_nxt == 8'd0) begin
                  crc_left_nxt = 2'd2;
                end
              end else begin
                done_nxt = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      is_b_r     <= 1'b0;
      has2_r     <= 1'b0;
      done_r     <= 1'b0;
      blk_no_r   <= 1'b0;
      ds_r       <= '0;
      di_r       <= '0;
      rem_r      <= '0;
      crc_left_r <= '0;
      crc_word_r <= '0;
      fold_r     <= '0;
      nfp_r      <= 9'(LINK_HDR_LEN);
      kind_r     <= KIND_LINK;
      hdr_len_r  <= '0;
      id1_r      <= '{man: 16'hFFFF, dev_type: 8'hFF, serial: 32'hFFFF_FFFF, len: 8'd0};
      id2_r      <= '{man: 16'hFFFF, dev_type: 8'hFF, serial: 32'hFFFF_FFFF, len: 8'd0};
    end else begin
      in_frame_r <= in_frame_nxt;
      is_b_r     <= is_b_nxt;
      has2_r     <= has2_nxt;
      done_r     <= done_nxt;
      blk_no_r   <= blk_no_nxt;
      ds_r       <= ds_nxt;
      di_r       <= di_nxt;
      rem_r      <= rem_nxt;
      crc_left_r <= crc_left_nxt;
      crc_word_r <= crc_word_nxt;
      fold_r     <= fold_nxt;
      nfp_r      <= nfp_nxt;
      kind_r     <= kind_nxt;
      hdr_len_r  <= hdr_len_nxt;
      id1_r      <= id1_nxt;
      id2_r      <= id2_nxt;
    end
  end

  // A data block and a CRC pair are never pending at the same time.
  a_block_or_crc: assert property (@(posedge clk) disable iff (!rst_n)
    !((rem_r != 8'd0) && (crc_left_r != 2'd0)))
    else $error("data block and CRC pair both pending");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    di_r <= ds_r)
    else $error("data index ran past data size");

  // Any result request closes the frame.
  a_eop_closes: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> !in_frame_r)
    else $error("frame still open after end of packet");

endmodule

/* hdl/wmbus_frame_deframe_header_parse_top.sv */
// Top level of the wireless M-Bus frame deframer and header parser.
// An end-of-packet request is registered in the front queue, and its result is registered
// in the result queue.
// Throughput: one request and one parser byte per cycle while the result queue has room.
// A result waits in a two-entry result queue; the front queue holds two requests.
// Reset (synchronous, rst_n low): queues empty, parser closed, wildcards all ones.
`timescale 1ns / 1ps
module wmbus_frame_deframe_header_parse_top
  import wfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  wfd_in_t     in_data,
  output logic        out_empty,
  input  logic        out_pop,
  output wfd_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic     q_valid;
  logic     q_pop;
  wfd_cmd_t q_cmd;
  logic     res_push;
  logic     res_full;
  wfd_out_t res_data;

  wfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  wfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  wfd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/wmbus_frame_deframe_header_parse_top_test.sv */
// Self-checking test of the wireless M-Bus deframer and header parser.
`timescale 1ns / 1ps
module wmbus_frame_deframe_header_parse_top_test;
  import wfd_pkg::*;

  typedef struct {
    logic [15:0] man;
    logic [7:0]  dev_type;
    logic [31:0] serial;
    logic [7:0]  len;
  } dev_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  wfd_in_t     in_data = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  wfd_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_WILD_MAN;
  logic [31:0] cfg_wdata = '0;

  wmbus_frame_deframe_header_parse_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wfd_in_t  pending_bytes[$];
  wfd_out_t expected_ids[$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       in_taken = 1'b0;

  // Predictor state.
  logic [15:0] w_man = 16'hFFFF;
  logic [7:0]  w_type = 8'hFF;
  logic [31:0] w_serial = 32'hFFFFFFFF;
  bit          open_frame, is_b, two_blocks, finished;
  int          dsize, didx, blk_left, crc_left, blk_no, b_len, next_pos;
  logic [15:0] crc_acc;
  logic [31:0] folded;
  kind_t       kind;
  dev_rec_t    id1, id2;

  function automatic dev_rec_t wild_id();
    dev_rec_t d;
    d.man = w_man; d.dev_type = w_type; d.serial = w_serial; d.len = 8'd0;
    return d;
  endfunction

  function automatic bit is_set(dev_rec_t d);
    return d.man != w_man && d.dev_type != w_type && d.serial != w_serial && d.len != 0;
  endfunction

  function automatic logic [7:0] len_to_end(int p);
    return 8'((dsize - p) & 255);
  endfunction

  task automatic parse_header(int pos, logic [7:0] b);
    int k;
    if (pos < LINK_HDR_LEN) begin
      case (pos)
        0: id1.len = is_b ? 8'(b_len) : b;
        2: id1.man[7:0] = b;
        3: id1.man[15:8] = b;
        4: id1.serial = {24'd0, b};
        5: id1.serial[15:8] = b;
        6: id1.serial[23:16] = b;
        7: id1.serial[31:24] = b;
        9: begin
          id1.dev_type = b;
          kind = KIND_FIELD;
        end
        default: ;
      endcase
    end else if (kind == KIND_FIELD && pos == next_pos) begin
      if (b == CI_ELL_SHORT) begin
        next_pos = pos + 3;
        id1.len = len_to_end(next_pos);
      end else if (b == CI_AFL) begin
        kind = KIND_AFL_LEN;
      end else if (b == CI_TPL_LONG) begin
        id2 = id1;
        id1.man = '0; id1.dev_type = '0; id1.serial = '0;
        kind = KIND_TPL;
      end else begin
        kind = KIND_DONE;
      end
    end else if (kind == KIND_AFL_LEN && pos == next_pos + 1) begin
      next_pos = pos + 1 + b;
      id1.len = len_to_end(next_pos);
      kind = KIND_FIELD;
    end else if (kind == KIND_TPL && pos > next_pos) begin
      k = pos - next_pos;
      if (k >= 1 && k <= 4) id1.serial |= 32'(b) << (8 * (k - 1));
      else if (k == 5) id1.man |= 16'(b);
      else if (k == 6) id1.man |= 16'(b) << 8;
      else if (k == 8) begin
        id1.dev_type = b;
        kind = KIND_DONE;
      end
    end
  endtask

  task automatic take_byte(logic [7:0] b);
    if (finished) return;
    if (blk_left > 0) begin
      parse_header(didx, b);
      didx++;
      blk_left--;
      if (blk_left == 0) crc_left = 2;
      return;
    end
    if (crc_left == 0) begin
      finished = 1;
      return;
    end
    crc_acc = {crc_acc[7:0], b};
    crc_left--;
    if (crc_left != 0) return;
    folded = (folded << 8) ^ {16'd0, crc_acc};
    if (!is_b) begin
      if (didx < dsize) blk_left = (dsize - didx < A_OTHER_BLOCK) ? dsize - didx : A_OTHER_BLOCK;
      else finished = 1;
    end else if (blk_no == 0 && two_blocks) begin
      blk_no = 1;
      blk_left = dsize - didx;
      if (blk_left == 0) crc_left = 2;
    end else begin
      finished = 1;
    end
  endtask

  task automatic open_new_frame(logic [7:0] l, bit fmt_b);
    int e, b2;
    open_frame = 1; is_b = fmt_b; finished = 0; folded = '0; crc_acc = '0;
    didx = 0; blk_no = 0; next_pos = LINK_HDR_LEN; kind = KIND_LINK;
    id1 = wild_id(); id2 = wild_id();
    if (!fmt_b) begin
      dsize = l + 1;
      blk_left = dsize < A_FIRST_BLOCK ? dsize : A_FIRST_BLOCK;
      two_blocks = 0; b_len = 0;
    end else begin
      e = int'(l) - 1;
      if (e > B_L_ADJUST) e -= 2;
      two_blocks = e > B_FIRST_BLOCK;
      if (two_blocks) begin
        b2 = e - 127;
        if (b2 > B_SECOND_MAX) b2 = B_SECOND_MAX;
        dsize = B_FIRST_BLOCK + b2;
        blk_left = B_FIRST_BLOCK;
      end else begin
        dsize = e > 0 ? e : 0;
        blk_left = dsize;
      end
      b_len = (e - 1) & 255;
    end
    crc_left = blk_left == 0 ? 2 : 0;
  endtask

  task automatic predict_request(wfd_in_t r);
    wfd_out_t o;
    dev_rec_t d1, d2, t;
    if (r.req_type == 1'b0) begin
      if (r.start_of_frame) open_new_frame(r.frame_byte, r.format_b);
      if (open_frame) take_byte(r.frame_byte);
      return;
    end
    d1 = wild_id(); d2 = wild_id();
    o = '0;
    if (open_frame) begin
      o.checksum = folded;
      if (finished && dsize >= LINK_HDR_LEN) begin
        if (kind == KIND_AFL_LEN) begin
          next_pos += 2;
          id1.len = len_to_end(next_pos);
          kind = KIND_FIELD;
        end
        d1 = id1; d2 = id2;
        if (is_set(d1) && is_set(d2) && d1.man[14:0] == SWAP_MAN && d1.dev_type == SWAP_TYPE)
        begin
          t = d1; d1 = d2; d2 = t;
        end
        o.ok = is_set(d1);
        o.dev2_present = is_set(d2);
      end
    end
    open_frame = 0;
    o.dev1_manufacturer = d1.man; o.dev1_type = d1.dev_type;
    o.dev1_serial = d1.serial; o.dev1_length = d1.len;
    o.dev2_manufacturer = d2.man; o.dev2_type = d2.dev_type;
    o.dev2_serial = d2.serial; o.dev2_length = d2.len;
    o.link_quality_out = r.link_quality;
    expected_ids = {expected_ids, o};
  endtask

  // Driver: one request per accepted handshake, idle gaps at random.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        predict_request(in_data);
        void'(pending_bytes.pop_front());
      end
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_bytes[0];
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
        in_data <= wfd_in_t'({$urandom, $urandom});
      end
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each popped result with the oldest expectation.
  always @(posedge clk) begin
    wfd_out_t e;
    // The request handshake is judged at the rising edge, where it takes effect.
    in_taken = rst_n && in_push && !in_full;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_ids.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        e = expected_ids.pop_front();
        if (out_data.ok !== e.ok)
          begin $error("ok exp %h got %h", e.ok, out_data.ok); errors++; end
        if (out_data.dev1_manufacturer !== e.dev1_manufacturer)
          begin $error("dev1_manufacturer exp %h got %h", e.dev1_manufacturer,
                       out_data.dev1_manufacturer); errors++; end
        if (out_data.dev1_type !== e.dev1_type)
          begin $error("dev1_type exp %h got %h", e.dev1_type, out_data.dev1_type);
                errors++; end
        if (out_data.dev1_serial !== e.dev1_serial)
          begin $error("dev1_serial exp %h got %h", e.dev1_serial, out_data.dev1_serial);
                errors++; end
        if (out_data.dev1_length !== e.dev1_length)
          begin $error("dev1_length exp %h got %h", e.dev1_length, out_data.dev1_length);
                errors++; end
        if (out_data.dev2_present !== e.dev2_present)
          begin $error("dev2_present exp %h got %h", e.dev2_present, out_data.dev2_present);
                errors++; end
        if (out_data.dev2_manufacturer !== e.dev2_manufacturer)
          begin $error("dev2_manufacturer exp %h got %h", e.dev2_manufacturer,
                       out_data.dev2_manufacturer); errors++; end
        if (out_data.dev2_type !== e.dev2_type)
          begin $error("dev2_type exp %h got %h", e.dev2_type, out_data.dev2_type);
                errors++; end
        if (out_data.dev2_serial !== e.dev2_serial)
          begin $error("dev2_serial exp %h got %h", e.dev2_serial, out_data.dev2_serial);
                errors++; end
        if (out_data.dev2_length !== e.dev2_length)
          begin $error("dev2_length exp %h got %h", e.dev2_length, out_data.dev2_length);
                errors++; end
        if (out_data.checksum !== e.checksum)
          begin $error("checksum exp %h got %h", e.checksum, out_data.checksum); errors++; end
        if (out_data.link_quality_out !== e.link_quality_out)
          begin $error("link_quality_out exp %h got %h", e.link_quality_out,
                       out_data.link_quality_out); errors++; end
      end
    end
  end

  function automatic wfd_in_t mk_byte(logic [7:0] b, bit sof, bit fmt);
    wfd_in_t r;
    r = wfd_in_t'({$urandom, $urandom});
    r.req_type = 1'b0; r.frame_byte = b; r.start_of_frame = sof; r.format_b = fmt;
    return r;
  endfunction

  task automatic queue_eop();
    wfd_in_t r;
    r = wfd_in_t'({$urandom, $urandom});
    r.req_type = 1'b1;
    pending_bytes = {pending_bytes, r};
  endtask

  // Total bytes on air for a frame, CRC pairs included.
  function automatic int air_length(logic [7:0] l, bit fmt);
    int e, n, sz;
    if (!fmt) begin
      sz = l + 1;
      n = (sz <= A_FIRST_BLOCK) ? 1 : 1 + (sz - A_FIRST_BLOCK + A_OTHER_BLOCK - 1) / A_OTHER_BLOCK;
      return sz + 2 * n;
    end
    e = int'(l) - 1;
    if (e > B_L_ADJUST) e -= 2;
    if (e <= B_FIRST_BLOCK) return (e > 0 ? e : 0) + 2;
    sz = e - 127;
    if (sz > B_SECOND_MAX) sz = B_SECOND_MAX;
    return B_FIRST_BLOCK + sz + 4;
  endfunction

  // Builds a frame with a plausible header chain and random content.
  task automatic queue_frame(logic [7:0] l, bit fmt, int chain, int cut, bit itw);
    logic [7:0] body[$];
    int n, p;
    n = air_length(l, fmt);
    for (int i = 0; i < n; i++) body = {body, 8'($urandom)};
    body[0] = l;
    if (itw && n > 12) begin
      body[2] = 8'h97; body[3] = 8'(($urandom_range(1) << 7) | 8'h26); body[9] = SWAP_TYPE;
    end
    // Data offsets of fields after the link header; CRC pairs shift them a bit,
    // which is fine: the content stays random either way.
    p = fmt ? 10 : 12;
    case (chain)
      1: if (p < n) body[p] = CI_ELL_SHORT;
      2: if (p + 1 < n) begin
        body[p] = CI_AFL; body[p + 1] = 8'($urandom_range(6));
      end
      3: if (p < n) body[p] = CI_TPL_LONG;
      4: if (p + 4 < n) begin
        body[p] = CI_ELL_SHORT; body[p + 3] = CI_TPL_LONG;
      end
      default: ;
    endcase
    if (cut > 0 && cut < n) n = cut;
    if ($urandom_range(9) == 0) n += $urandom_range(3);
    for (int i = 0; i < n; i++)
      pending_bytes = {pending_bytes,
                       mk_byte(i < body.size() ? body[i] : 8'($urandom), i == 0, fmt)};
    queue_eop();
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || expected_ids.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_wild(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    case (idx)
      REG_WILD_MAN:  w_man = v[15:0];
      REG_WILD_TYPE: w_type = v[7:0];
      default:       w_serial = v;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int frames);
    int pick;
    logic [7:0] l;
    for (int i = 0; i < frames; i++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        // stray bytes with no frame open, then an end of packet
        for (int j = 0; j < 3; j++) pending_bytes = {pending_bytes, mk_byte(8'($urandom), 0, 0)};
        queue_eop();
      end else begin
        l = (pick < 90) ? 8'($urandom_range(9, 40)) : 8'($urandom);
        queue_frame(l, $urandom_range(1), $urandom_range(4),
                    ($urandom_range(9) == 0) ? $urandom_range(1, 15) : 0,
                    $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Directed: no frame, short frames, size extremes, each field kind, swap case.
    queue_eop();
    queue_frame(8'd0, 0, 0, 0, 0);
    queue_frame(8'd5, 1, 0, 0, 0);
    queue_frame(8'd9, 0, 1, 0, 0);
    queue_frame(8'd20, 0, 2, 0, 0);
    queue_frame(8'd20, 1, 3, 0, 1);
    queue_frame(8'd30, 0, 4, 0, 1);
    queue_frame(8'd20, 0, 3, 7, 0);
    queue_frame(8'd127, 1, 1, 0, 0);
    queue_frame(8'd129, 1, 2, 0, 0);
    queue_frame(8'd255, 1, 3, 0, 0);
    queue_frame(8'd255, 0, 0, 0, 0);
    queue_frame(8'd1, 1, 0, 0, 0);
    wait_drained();
    random_phase(3);
    wait_drained();
    send_idle_pct = 45;
    random_phase(2);
    wait_drained();
    write_wild(REG_WILD_MAN, 32'h0);
    write_wild(REG_WILD_TYPE, 32'h0);
    write_wild(REG_WILD_SERIAL, 32'h0);
    send_idle_pct = 0; recv_stall_pct = 45;
    random_phase(3);
    wait_drained();
    write_wild(REG_WILD_MAN, $urandom);
    write_wild(REG_WILD_TYPE, $urandom);
    write_wild(REG_WILD_SERIAL, $urandom);
    send_idle_pct = 17; recv_stall_pct = 17;
    random_phase(2);
    wait_drained();
    write_wild(REG_WILD_MAN, 32'hFFFF);
    write_wild(REG_WILD_TYPE, 32'hFF);
    write_wild(REG_WILD_SERIAL, 32'hFFFFFFFF);
    send_idle_pct = 0; recv_stall_pct = 0;
    random_phase(2);
    wait_drained();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
